### rtl/lfps_pkg.sv
// Package for the five-point Laplacian stencil unit.
// Holds register indexes, field widths, reset values and parameter defaults.
// No dependencies.
package lfps_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 18;

	localparam int LAP_BITS  = 48;
	localparam int GEOM_BITS = 11;
	localparam int INV_BITS  = 24;
	localparam int ROW_BITS  = GEOM_BITS + 1;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_PATCH_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATCH_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INV_DX_SQ    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INV_DY_SQ    = 2'd3;

	localparam logic [GEOM_BITS-1:0] PATCH_WIDTH_RST  = 11'd64;
	localparam logic [GEOM_BITS-1:0] PATCH_HEIGHT_RST = 11'd64;
	localparam logic [INV_BITS-1:0]  INV_DX_SQ_RST    = 24'd1048576;
	localparam logic [INV_BITS-1:0]  INV_DY_SQ_RST    = 24'd1048576;

endpackage

### rtl/lfps_sample_if.sv
// Sample channel of the five-point Laplacian stencil unit.
// Valid/ready transaction carrying one signed raster sample.
// Depends on nothing.
interface lfps_sample_if #(
	parameter int SAMPLE_BITS = 18
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### rtl/lfps_result_if.sv
// Result channel of the five-point Laplacian stencil unit.
// Valid/ready transaction carrying one Laplacian value and a last flag.
// Depends on lfps_pkg.
interface lfps_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lfps_pkg::LAP_BITS-1:0] laplacian;
	logic                                 last_cell;

	modport source (output valid, output laplacian, output last_cell, input ready);
	modport sink (input valid, input laplacian, input last_cell, output ready);
endinterface

### rtl/laplacian_five_point_stencil_unit.sv
// Top level of the five-point Laplacian stencil unit.
// Depends on lfps_pkg, lfps_sample_if and lfps_result_if.
//
// Takes one raster sample per clock while results are taken, over a patch with
// one ghost cell on each side, and emits the Laplacian of every interior cell,
// Q28.20, with a flag on the last cell; the two line stores allow that rate, each
// read at one address and written at another. A result is computed when the
// sample at its upper-right diagonal is taken and passes the s1, s2, s3 and
// output registers; a stall can hold it in any of them. The line stores are not
// cleared; the first two rows of each patch fill them before any result depends
// on them. Samples in the first two rows and first two columns make no result.
module laplacian_five_point_stencil_unit #(
	parameter int MAX_WIDTH   = lfps_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lfps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [lfps_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
	lfps_sample_if.sink                            samples,
	lfps_result_if.source                          results
);

	localparam int DEPTH = MAX_WIDTH + 2;
	localparam int CW    = $clog2(DEPTH);
	localparam int CMP_W = ((CW > lfps_pkg::GEOM_BITS) ? CW : lfps_pkg::GEOM_BITS) + 1;
	localparam int RW    = lfps_pkg::ROW_BITS;
	localparam int SB    = SAMPLE_BITS;
	localparam int DW    = SB + 3;
	localparam int MW    = lfps_pkg::INV_BITS + 1;
	localparam int PW    = DW + MW;
	localparam int SUM_W = (PW + 1 > lfps_pkg::LAP_BITS) ? PW + 1 : lfps_pkg::LAP_BITS;
	localparam int LB    = lfps_pkg::LAP_BITS;

	logic [lfps_pkg::GEOM_BITS-1:0] width_q;
	logic [lfps_pkg::GEOM_BITS-1:0] height_q;
	logic [lfps_pkg::INV_BITS-1:0]  inv_dx_q;
	logic [lfps_pkg::INV_BITS-1:0]  inv_dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lfps_pkg::PATCH_WIDTH_RST;
			height_q <= lfps_pkg::PATCH_HEIGHT_RST;
			inv_dx_q <= lfps_pkg::INV_DX_SQ_RST;
			inv_dy_q <= lfps_pkg::INV_DY_SQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfps_pkg::REG_PATCH_WIDTH:  width_q  <= cfg_wdata[lfps_pkg::GEOM_BITS-1:0];
				lfps_pkg::REG_PATCH_HEIGHT: height_q <= cfg_wdata[lfps_pkg::GEOM_BITS-1:0];
				lfps_pkg::REG_INV_DX_SQ:    inv_dx_q <= cfg_wdata[lfps_pkg::INV_BITS-1:0];
				lfps_pkg::REG_INV_DY_SQ:    inv_dy_q <= cfg_wdata[lfps_pkg::INV_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Raster position
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [CMP_W-1:0] width_ext;
	logic [CMP_W-1:0] width_eff;
	logic [RW-1:0]    height_eff;
	logic             wrap_col;
	logic             wrap_row;
	logic             produce;

	always_comb begin
		width_ext = CMP_W'(width_q);
		if (width_q == '0)
			width_eff = CMP_W'(1);
		else if (width_ext > CMP_W'(MAX_WIDTH))
			width_eff = CMP_W'(MAX_WIDTH);
		else
			width_eff = width_ext;
		height_eff = (height_q == '0) ? RW'(1) : RW'(height_q);
		wrap_col   = CMP_W'(col_q) >= width_eff + CMP_W'(1);
		wrap_row   = row_q >= height_eff + RW'(1);
		produce    = (row_q >= RW'(2)) && (CMP_W'(col_q) >= CMP_W'(2));
	end

	// Pipeline flow
	logic v_s1, v_s2, v_s3, v_out_q;
	logic out_free, s3_free, s2_free;
	logic adv1, adv2, adv3, acc;
	logic prod_s1;

	assign out_free      = !v_out_q || results.ready;
	assign s3_free       = !v_s3 || out_free;
	assign s2_free       = !v_s2 || s3_free;
	assign adv3          = v_s3 && out_free;
	assign adv2          = v_s2 && s3_free;
	assign adv1          = v_s1 && (s2_free || !prod_s1);
	assign samples.ready = !v_s1 || adv1;
	assign acc           = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (acc) begin
				if (wrap_col) begin
					col_q <= '0;
					row_q <= wrap_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (acc)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1 && prod_s1)
				v_s2 <= 1'b1;
			else if (adv2)
				v_s2 <= 1'b0;
			if (adv2)
				v_s3 <= 1'b1;
			else if (adv3)
				v_s3 <= 1'b0;
			if (adv3)
				v_out_q <= 1'b1;
			else if (results.ready)
				v_out_q <= 1'b0;
		end
	end

	// Line stores
	logic signed [SB-1:0] older_mem [DEPTH];
	logic signed [SB-1:0] prev_mem [DEPTH];
	logic signed [SB-1:0] older_rd_s1;
	logic signed [SB-1:0] prev_rd_s1;
	logic signed [SB-1:0] sample_s1;
	logic [CW-1:0]        addr_s1;
	logic                 last_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			older_rd_s1 <= older_mem[col_q];
			prev_rd_s1  <= prev_mem[col_q];
			sample_s1   <= samples.sample;
			addr_s1     <= col_q;
			prod_s1     <= produce;
			last_s1     <= wrap_row && wrap_col;
		end
		if (adv1) begin
			older_mem[addr_s1] <= prev_rd_s1;
			prev_mem[addr_s1]  <= sample_s1;
		end
	end

	// Window and vertical neighbors
	logic signed [SB-1:0] win_a_q;
	logic signed [SB-1:0] win_b_q;
	logic signed [SB-1:0] below_q;
	logic signed [SB-1:0] above_q;
	logic signed [DW-1:0] dxx;
	logic signed [DW-1:0] dyy;
	logic signed [DW-1:0] centre2;

	always_comb begin
		centre2 = DW'(win_b_q) <<< 1;
		dxx     = DW'(win_a_q) - centre2 + DW'(prev_rd_s1);
		dyy     = DW'(below_q) - centre2 + DW'(above_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_a_q <= '0;
			win_b_q <= '0;
			below_q <= '0;
			above_q <= '0;
		end else if (adv1) begin
			win_a_q <= win_b_q;
			win_b_q <= prev_rd_s1;
			below_q <= older_rd_s1;
			above_q <= sample_s1;
		end
	end

	// Scale, sum, hold result
	logic signed [DW-1:0]  dxx_s2, dyy_s2;
	logic                  last_s2;
	logic signed [PW-1:0]  prod_x_s3, prod_y_s3;
	logic                  last_s3;
	logic signed [LB-1:0]  lap_q;
	logic                  last_q;
	logic signed [SUM_W-1:0] sum;

	assign sum = SUM_W'(prod_x_s3) + SUM_W'(prod_y_s3);

	always_ff @(posedge clk) begin
		if (adv1 && prod_s1) begin
			dxx_s2  <= dxx;
			dyy_s2  <= dyy;
			last_s2 <= last_s1;
		end
		if (adv2) begin
			prod_x_s3 <= PW'(dxx_s2) * PW'($signed({1'b0, inv_dx_q}));
			prod_y_s3 <= PW'(dyy_s2) * PW'($signed({1'b0, inv_dy_q}));
			last_s3   <= last_s2;
		end
		if (adv3) begin
			lap_q  <= sum[LB-1:0];
			last_q <= last_s3;
		end
	end

	assign results.valid     = v_out_q;
	assign results.laplacian = lap_q;
	assign results.last_cell = last_q;

endmodule

### verif/laplacian_five_point_stencil_unit_tb.sv
// Testbench for laplacian_five_point_stencil_unit: raster patches in, Laplacians out.
// Needs lfps_pkg, lfps_sample_if, lfps_result_if and the unit from the rtl folder.
// A directed table runs first, then random patches checked against a line-buffer predictor.
`timescale 1ns / 100ps

module laplacian_five_point_stencil_unit_tb;
	import lfps_pkg::*;

	localparam int SW          = SAMPLE_BITS_DEF;
	localparam int ROW_SLOTS   = MAX_WIDTH_DEF + 2;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 8;
	localparam int RANDOM_ITEMS = 500;
	localparam int WIDE_SAMPLES = 40;
	localparam int TALL_SAMPLES = 120;

	localparam logic signed [SW-1:0] S_MAX = 18'sd131071;
	localparam logic signed [SW-1:0] S_MIN = -18'sd131072;

	typedef struct packed {
		logic signed [LAP_BITS-1:0] laplacian;
		logic                       last_cell;
	} cell_result_t;

	typedef struct packed {
		logic signed [SW-1:0] value;
		bit                   typed;
		cell_result_t         want;
	} raster_item_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [CFG_IDX_BITS-1:0]    reg_idx;
		logic [CFG_DATA_BITS-1:0]   reg_val;
		logic signed [SW-1:0]       value;
		logic signed [LAP_BITS-1:0] laplacian;
		logic                       last_cell;
	} stim_row_t;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_ONE_IN_THREE, RX_STARVED} rx_mode_t;

	stim_row_t directed_rows [26] = '{
		'{ROW_WRITE,   REG_PATCH_WIDTH,  24'd1,        18'sd0, 48'sd0, 1'b0},
		'{ROW_WRITE,   REG_PATCH_HEIGHT, 24'd1,        18'sd0, 48'sd0, 1'b0},
		'{ROW_WRITE,   REG_INV_DX_SQ,    24'd256,      18'sd0, 48'sd0, 1'b0},
		'{ROW_WRITE,   REG_INV_DY_SQ,    24'd256,      18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MAX,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MAX,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MIN,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MAX,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MAX,  48'sd0, 1'b0},
		'{ROW_CHECKED, REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd268434432, 1'b1},
		'{ROW_WRITE,   REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_WRITE,   REG_PATCH_HEIGHT, 24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_WRITE,   REG_INV_DX_SQ,    24'hFFFFFF,   18'sd0, 48'sd0, 1'b0},
		'{ROW_WRITE,   REG_INV_DY_SQ,    24'hFFFFFF,   18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MIN,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MIN,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MAX,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MIN,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        S_MIN,  48'sd0, 1'b0},
		'{ROW_SAMPLE,  REG_PATCH_WIDTH,  24'd0,        18'sd0, 48'sd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	lfps_sample_if #(.SAMPLE_BITS(SW)) samples ();
	lfps_result_if results ();

	laplacian_five_point_stencil_unit #(
		.MAX_WIDTH   (MAX_WIDTH_DEF),
		.SAMPLE_BITS (SW)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.results   (results)
	);

	always #5 clk = ~clk;

	// predictor state and register mirror
	logic [GEOM_BITS-1:0] cfg_width, cfg_height;
	logic [INV_BITS-1:0]  cfg_inv_dx, cfg_inv_dy;
	logic signed [SW-1:0] older_row [ROW_SLOTS];
	logic signed [SW-1:0] prev_row [ROW_SLOTS];
	logic signed [SW-1:0] mid_window [3];
	logic signed [SW-1:0] below_hold, above_hold;
	int unsigned col_pos, row_pos;

	raster_item_t raster_q [$];
	cell_result_t laplacians_due [$];
	int mismatches;
	int cells_seen;
	int hold_requests;

	function automatic int unsigned eff_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	function automatic bit advance_stencil(input logic signed [SW-1:0] s,
			output cell_result_t res);
		int unsigned w, h, c;
		logic signed [SW-1:0] from_older, from_prev;
		longint dxx, dyy, total;
		bit made;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		from_older = '0;
		from_prev = '0;
		made = 1'b0;
		res = '0;
		if (c < ROW_SLOTS) begin
			from_older = older_row[c];
			from_prev = prev_row[c];
			older_row[c] = from_prev;
			prev_row[c] = s;
		end
		mid_window[0] = mid_window[1];
		mid_window[1] = mid_window[2];
		mid_window[2] = from_prev;
		if (row_pos >= 2 && c >= 2) begin
			dxx = longint'(mid_window[0]) - 2 * longint'(mid_window[1])
				+ longint'(mid_window[2]);
			dyy = longint'(below_hold) - 2 * longint'(mid_window[1]) + longint'(above_hold);
			total = dxx * longint'(cfg_inv_dx) + dyy * longint'(cfg_inv_dy);
			res.laplacian = total[LAP_BITS-1:0];
			res.last_cell = (row_pos >= h + 1) && (c >= w + 1);
			made = 1'b1;
		end
		below_hold = from_older;
		above_hold = s;
		if (c >= w + 1) begin
			col_pos = 0;
			row_pos = (row_pos >= h + 1) ? 0 : row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
		return made;
	endfunction

	function automatic int samples_left(input int unsigned c0, input int unsigned r0);
		int unsigned w, h, c, r;
		int n;
		w = eff_width();
		h = eff_height();
		c = c0;
		r = r0;
		n = 0;
		do begin
			n++;
			if (c >= w + 1) begin
				c = 0;
				r = (r >= h + 1) ? 0 : r + 1;
			end else begin
				c++;
			end
		end while (c != 0 || r != 0);
		return n;
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return SW'(int'($urandom_range(0, 32)) - 16);
			default: return SW'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] rand_inv();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(1, 1024));
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic drain();
		do
			@(posedge clk);
		while (raster_q.size() != 0 || samples.valid || laplacians_due.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PATCH_WIDTH:  cfg_width = val[GEOM_BITS-1:0];
			REG_PATCH_HEIGHT: cfg_height = val[GEOM_BITS-1:0];
			REG_INV_DX_SQ:    cfg_inv_dx = val[INV_BITS-1:0];
			REG_INV_DY_SQ:    cfg_inv_dy = val[INV_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic feed_raster(input int n);
		raster_item_t item;
		item = '0;
		repeat (n) begin
			item.value = rand_sample();
			raster_q.push_back(item);
		end
	endtask

	// sender: bursts with random gaps, prediction on each accepted transaction
	int burst_left, gap_left;
	raster_item_t taken;
	cell_result_t predicted;

	always @(posedge clk) begin
		if (!arst_n) begin
			samples.valid <= 1'b0;
			samples.sample <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (samples.valid && samples.ready) begin
				taken = raster_q.pop_front();
				if (advance_stencil(taken.value, predicted) && !taken.typed)
					laplacians_due.push_back(predicted);
				if (taken.typed)
					laplacians_due.push_back(taken.want);
			end
			if (!samples.valid || samples.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					samples.valid <= 1'b0;
				end else if (raster_q.size() != 0) begin
					samples.valid <= 1'b1;
					samples.sample <= raster_q[0].value;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern per segment, plus long holds on request
	rx_mode_t rx_mode;
	int mode_left, hold_left, hold_seen, rx_tick;

	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			mode_left = 0;
			hold_left = 0;
			hold_seen = 0;
			rx_tick = 0;
		end else begin
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				rx_tick++;
				case (rx_mode)
					RX_STEADY:       results.ready <= 1'b1;
					RX_COIN:         results.ready <= $urandom_range(0, 1);
					RX_ONE_IN_THREE: results.ready <= (rx_tick % 3) == 0;
					RX_STARVED:      results.ready <= $urandom_range(0, 7) == 0;
					default:         results.ready <= 1'b1;
				endcase
			end
		end
	end

	cell_result_t due;

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			cells_seen++;
			if (laplacians_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cell %0d: unexpected result laplacian %0d last_cell %0b",
						cells_seen, results.laplacian, results.last_cell);
			end else begin
				due = laplacians_due.pop_front();
				if (results.laplacian !== due.laplacian || results.last_cell !== due.last_cell) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cell %0d: expected %0d/%0b, got %0d/%0b", cells_seen,
							due.laplacian, due.last_cell, results.laplacian, results.last_cell);
				end
			end
		end
	end

	int quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int n, k, random_items;
		raster_item_t item;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cfg_width = PATCH_WIDTH_RST;
		cfg_height = PATCH_HEIGHT_RST;
		cfg_inv_dx = INV_DX_SQ_RST;
		cfg_inv_dy = INV_DY_SQ_RST;
		mid_window = '{default: '0};
		below_hold = '0;
		above_hold = '0;
		col_pos = 0;
		row_pos = 0;
		mismatches = 0;
		cells_seen = 0;
		hold_requests = 0;
		random_items = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				item.value = directed_rows[i].value;
				item.typed = directed_rows[i].kind == ROW_CHECKED;
				item.want.laplacian = directed_rows[i].laplacian;
				item.want.last_cell = directed_rows[i].last_cell;
				raster_q.push_back(item);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				case ($urandom_range(0, 9))
					0: write_reg(REG_PATCH_WIDTH, 0);
					1: write_reg(REG_PATCH_WIDTH, 1);
					8: write_reg(REG_PATCH_WIDTH, $urandom_range(9, 40));
					9: write_reg(REG_PATCH_WIDTH, $urandom_range(41, 100));
					default: write_reg(REG_PATCH_WIDTH, $urandom_range(2, 8));
				endcase
				write_reg(REG_PATCH_HEIGHT, $urandom_range(0, 6));
				write_reg(REG_INV_DX_SQ, rand_inv());
				write_reg(REG_INV_DY_SQ, rand_inv());
			end
			n = samples_left(0, 0);
			// cut some patches short by shrinking the geometry mid-patch
			if ($urandom_range(0, 4) == 0) begin
				k = $urandom_range(1, n - 1);
				feed_raster(k);
				random_items += k;
				drain();
				if ($urandom_range(0, 1) == 1)
					write_reg(REG_PATCH_WIDTH, $urandom_range(0, eff_width()));
				else
					write_reg(REG_PATCH_HEIGHT, $urandom_range(0, eff_height()));
				if ($urandom_range(0, 1) == 1)
					write_reg(REG_INV_DX_SQ, rand_inv());
				n = samples_left(col_pos, row_pos);
			end
			feed_raster(n);
			random_items += n;
		end

		// width above the store depth, row cut once it runs past the narrow width
		drain();
		write_reg(REG_PATCH_WIDTH, 11'h7FF);
		write_reg(REG_PATCH_HEIGHT, 1);
		write_reg(REG_INV_DX_SQ, rand_inv());
		write_reg(REG_INV_DY_SQ, rand_inv());
		feed_raster(WIDE_SAMPLES);
		drain();
		write_reg(REG_PATCH_WIDTH, 2);
		feed_raster(samples_left(col_pos, row_pos));

		// tall patch under a long receiver hold, ended early by a height write
		drain();
		write_reg(REG_PATCH_WIDTH, 0);
		write_reg(REG_PATCH_HEIGHT, 11'h7FF);
		write_reg(REG_INV_DX_SQ, 24'hFFFFFF);
		write_reg(REG_INV_DY_SQ, rand_inv());
		hold_requests++;
		feed_raster(TALL_SAMPLES);
		drain();
		write_reg(REG_PATCH_HEIGHT, 1);
		feed_raster(samples_left(col_pos, row_pos));

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && laplacians_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### laplacian_five_point_stencil_unit.f
rtl/lfps_pkg.sv
rtl/lfps_sample_if.sv
rtl/lfps_result_if.sv
rtl/laplacian_five_point_stencil_unit.sv
verif/laplacian_five_point_stencil_unit_tb.sv
